### sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK_RST(lbl, c, r, p) \
  lbl: assert property (@(posedge c) disable iff (r) (p)) \
    else $error("assertion failed");

// Check a property on every clock edge, reset included.
`define ASSERT_CLK(lbl, c, p) \
  lbl: assert property (@(posedge c) (p)) \
    else $error("assertion failed");

`endif

### sv/crhc_pkg.sv
// ----------------------------------------------------------------------------
// crhc_pkg
// Types and constants of the RGB/HSV colour converter.
// ----------------------------------------------------------------------------
`default_nettype none

package crhc_pkg;

  localparam int CH_W   = 12;
  localparam int HUE_W  = 13;
  localparam int NUM_W  = 34;  // widest dividend
  localparam int DEN_W  = 22;  // widest divisor
  localparam int Q_W    = 12;  // every quotient fits here

  localparam logic [CH_W-1:0]  CH_FULL    = 12'd4095;
  localparam logic [HUE_W-1:0] HUE_SECTOR = 13'd960;
  localparam logic [HUE_W-1:0] HUE_TURN   = 13'd5760;
  localparam logic [DEN_W-1:0] MID_DEN    = 22'd3931200;  // CH_FULL * HUE_SECTOR

  localparam logic CMD_TO_HSV = 1'b0;
  localparam logic CMD_TO_RGB = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [HUE_W-1:0] in_a;
    logic [CH_W-1:0]  in_b;
    logic [CH_W-1:0]  in_c;
  } req_t;

  typedef struct packed {
    logic [HUE_W-1:0] out_a;
    logic [CH_W-1:0]  out_b;
    logic [CH_W-1:0]  out_c;
  } rsp_t;

  // Sideband carried alongside the divider pipe.
  typedef struct packed {
    logic            cmd;
    logic            neg;       // hue difference was negative
    logic            zero_hue;  // grey or black
    logic            zero_sat;  // black
    logic [2:0]      sect;      // base sector (hsv) or hue sector (rgb)
    logic [CH_W-1:0] top;       // max channel (hsv) or value (rgb)
  } side_t;

endpackage

`default_nettype wire

### sv/crhc_front.sv
// ----------------------------------------------------------------------------
// crhc_front
// Five register stages that reduce a request to two dividend/divisor pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module crhc_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire crhc_pkg::req_t                      req,
  output logic                                     out_valid,
  output logic [crhc_pkg::NUM_W-1:0]               num1,
  output logic [crhc_pkg::DEN_W-1:0]               den1,
  output logic [crhc_pkg::NUM_W-1:0]               num2,
  output logic [crhc_pkg::DEN_W-1:0]               den2,
  output crhc_pkg::side_t                          side
);

  localparam int CW = crhc_pkg::CH_W;
  localparam int HW = crhc_pkg::HUE_W;
  localparam int NW = crhc_pkg::NUM_W;
  localparam int DW = crhc_pkg::DEN_W;

  // Stage 1: input register
  logic           v1;
  crhc_pkg::req_t r1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= in_valid;
    r1 <= req;
  end

  // Stage 2: max/min for hsv, hue sector for rgb
  logic [CW-1:0] cr, cg, cb, mx_c, mn_c;
  logic [1:0]    sel_c;
  logic [HW-1:0] hw_c, frac_c;
  logic [2:0]    sec_c;

  always_comb begin
    cr = r1.in_a[CW-1:0];
    cg = r1.in_b;
    cb = r1.in_c;
    mx_c = cr;
    mn_c = cr;
    if (cg > mx_c) mx_c = cg;
    if (cb > mx_c) mx_c = cb;
    if (cg < mn_c) mn_c = cg;
    if (cb < mn_c) mn_c = cb;
    if (cr >= cg && cr >= cb) sel_c = 2'd0;
    else if (cg >= cb)        sel_c = 2'd1;
    else                      sel_c = 2'd2;
    hw_c = (r1.in_a >= crhc_pkg::HUE_TURN) ? r1.in_a - crhc_pkg::HUE_TURN : r1.in_a;
    if      (hw_c >= 13'd4800) sec_c = 3'd5;
    else if (hw_c >= 13'd3840) sec_c = 3'd4;
    else if (hw_c >= 13'd2880) sec_c = 3'd3;
    else if (hw_c >= 13'd1920) sec_c = 3'd2;
    else if (hw_c >= 13'd960)  sec_c = 3'd1;
    else                       sec_c = 3'd0;
    case (sec_c)
      3'd0:    frac_c = hw_c;
      3'd1:    frac_c = hw_c - 13'd960;
      3'd2:    frac_c = hw_c - 13'd1920;
      3'd3:    frac_c = hw_c - 13'd2880;
      3'd4:    frac_c = hw_c - 13'd3840;
      default: frac_c = hw_c - 13'd4800;
    endcase
  end

  logic          v2, cmd2;
  logic [CW-1:0] r2, g2, b2, mx2, mn2;
  logic [1:0]    sel2;
  logic [2:0]    sec2;
  logic [9:0]    frac2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    cmd2  <= r1.cmd;
    r2    <= cr;
    g2    <= cg;
    b2    <= cb;
    mx2   <= mx_c;
    mn2   <= mn_c;
    sel2  <= sel_c;
    sec2  <= sec_c;
    frac2 <= frac_c[9:0];
  end

  // Stage 3: delta and difference for hsv, mid-channel factor for rgb
  logic [CW-1:0] up_c, dn_c, delta_c, diff_c;
  logic          neg_c;
  logic [9:0]    tn_c, rem_c;
  logic [DW-1:0] p_c;

  always_comb begin
    delta_c = mx2 - mn2;
    case (sel2)
      2'd0:    begin up_c = g2; dn_c = b2; end
      2'd1:    begin up_c = b2; dn_c = r2; end
      default: begin up_c = r2; dn_c = g2; end
    endcase
    neg_c  = up_c < dn_c;
    diff_c = neg_c ? dn_c - up_c : up_c - dn_c;
    tn_c   = sec2[0] ? crhc_pkg::HUE_SECTOR[9:0] - frac2 : frac2;
    rem_c  = crhc_pkg::HUE_SECTOR[9:0] - tn_c;
    p_c    = DW'(g2) * DW'(rem_c);
  end

  logic          v3, cmd3, neg3;
  logic [CW-1:0] delta3, diff3, mx3, val3, sinv3;
  logic [2:0]    sect3;
  logic [DW-1:0] p3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    cmd3   <= cmd2;
    neg3   <= neg_c;
    delta3 <= delta_c;
    diff3  <= diff_c;
    mx3    <= mx2;
    val3   <= b2;
    sinv3  <= crhc_pkg::CH_FULL - g2;
    sect3  <= (cmd2 == crhc_pkg::CMD_TO_RGB) ? sec2 : {1'b0, sel2};
    p3     <= p_c;
  end

  // Stage 4: pick multiplier operands and divisors
  logic          v4;
  logic [CW-1:0] x1, y1, x2, add2;
  logic [DW-1:0] y2, d1, d2;
  crhc_pkg::side_t s4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
    if (cmd3 == crhc_pkg::CMD_TO_HSV) begin
      x1   <= delta3;
      y1   <= crhc_pkg::CH_FULL;
      x2   <= diff3;
      y2   <= DW'(crhc_pkg::HUE_SECTOR);
      add2 <= neg3 ? delta3 - 12'd1 : '0;
      d1   <= DW'(mx3);
      d2   <= DW'(delta3);
    end else begin
      x1   <= val3;
      y1   <= sinv3;
      x2   <= val3;
      y2   <= crhc_pkg::MID_DEN - p3;
      add2 <= '0;
      d1   <= DW'(crhc_pkg::CH_FULL);
      d2   <= crhc_pkg::MID_DEN;
    end
    s4.cmd      <= cmd3;
    s4.neg      <= neg3;
    s4.zero_hue <= (cmd3 == crhc_pkg::CMD_TO_HSV) && (delta3 == '0);
    s4.zero_sat <= (cmd3 == crhc_pkg::CMD_TO_HSV) && (mx3 == '0);
    s4.sect     <= sect3;
    s4.top      <= (cmd3 == crhc_pkg::CMD_TO_HSV) ? mx3 : val3;
  end

  // Stage 5: form the dividends
  logic [2*CW-1:0] prod1;
  assign prod1 = (2*CW)'(x1) * (2*CW)'(y1);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= v4;
    num1 <= NW'(prod1);
    num2 <= NW'(x2) * NW'(y2) + NW'(add2);
    den1 <= d1;
    den2 <= d2;
    side <= s4;
  end

endmodule

`default_nettype wire

### sv/crhc_div.sv
// ----------------------------------------------------------------------------
// crhc_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module crhc_div (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire logic [crhc_pkg::NUM_W-1:0]          num,
  input  wire logic [crhc_pkg::DEN_W-1:0]          den,
  input  wire crhc_pkg::side_t                     in_side,
  output logic                                     out_valid,
  output logic [crhc_pkg::Q_W-1:0]                 quo,
  output crhc_pkg::side_t                          out_side
);

  localparam int NW = crhc_pkg::NUM_W;
  localparam int DW = crhc_pkg::DEN_W;
  localparam int QW = crhc_pkg::Q_W;

  logic [NW-1:0]   rem  [0:QW];
  logic [DW-1:0]   dv   [0:QW];
  logic [QW-1:0]   q    [0:QW];
  crhc_pkg::side_t sd   [0:QW];
  logic            vld  [0:QW];

  assign rem[0] = num;
  assign dv[0]  = den;
  assign q[0]   = '0;
  assign sd[0]  = in_side;
  assign vld[0] = in_valid;

  // Each stage tries the divisor shifted to its bit and keeps the remainder
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW-1:0] shifted;
    logic          fits;
    assign shifted = {{(NW-DW){1'b0}}, dv[k]} << (QW-1-k);
    assign fits    = rem[k] >= shifted;

    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else     vld[k+1] <= vld[k];
      rem[k+1] <= fits ? rem[k] - shifted : rem[k];
      q[k+1]   <= {q[k][QW-2:0], fits};
      dv[k+1]  <= dv[k];
      sd[k+1]  <= sd[k];
    end
  end

  assign out_valid = vld[QW];
  assign quo       = q[QW];
  assign out_side  = sd[QW];

endmodule

`default_nettype wire

### sv/crhc_back.sv
// ----------------------------------------------------------------------------
// crhc_back
// Assembles hue or channel order from the quotients and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module crhc_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [crhc_pkg::Q_W-1:0]    q1,
  input  wire logic [crhc_pkg::Q_W-1:0]    q2,
  input  wire crhc_pkg::side_t             side,
  output logic                             done,
  output crhc_pkg::rsp_t                   rsp
);

  localparam int HW = crhc_pkg::HUE_W;
  localparam int CW = crhc_pkg::CH_W;

  logic [HW:0]     base, hue_raw;
  logic [HW-1:0]   hue;
  logic [CW-1:0]   hi, lo, mid, r, g, b;
  crhc_pkg::rsp_t  rsp_c;

  always_comb begin
    case (side.sect)
      3'd1:    base = 14'd1920;
      3'd2:    base = 14'd3840;
      default: base = 14'd0;
    endcase
    if (side.neg) hue_raw = base + 14'(crhc_pkg::HUE_TURN) - 14'(q2);
    else          hue_raw = base + 14'(q2);
    if (hue_raw >= 14'(crhc_pkg::HUE_TURN)) hue_raw = hue_raw - 14'(crhc_pkg::HUE_TURN);
    hue = side.zero_hue ? '0 : hue_raw[HW-1:0];

    hi  = side.top;
    lo  = q1;
    mid = q2;
    case (side.sect)
      3'd0:    begin r = hi;  g = mid; b = lo;  end
      3'd1:    begin r = mid; g = hi;  b = lo;  end
      3'd2:    begin r = lo;  g = hi;  b = mid; end
      3'd3:    begin r = lo;  g = mid; b = hi;  end
      3'd4:    begin r = mid; g = lo;  b = hi;  end
      default: begin r = hi;  g = lo;  b = mid; end
    endcase

    if (side.cmd == crhc_pkg::CMD_TO_HSV) begin
      rsp_c.out_a = hue;
      rsp_c.out_b = side.zero_sat ? '0 : q1;
      rsp_c.out_c = side.top;
    end else begin
      rsp_c.out_a = HW'(r);
      rsp_c.out_b = g;
      rsp_c.out_c = b;
    end
  end

  // Hold the result for one cycle under the strobe
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= in_valid;
    rsp <= rsp_c;
  end

endmodule

`default_nettype wire

### sv/color_rgb_hsv_convert.sv
// ----------------------------------------------------------------------------
// color_rgb_hsv_convert
// RGB to HSV and HSV to RGB conversion, fully pipelined.
// ----------------------------------------------------------------------------
//   channel   signals              direction   handshake
//   request   start, busy, req     in          taken when start && !busy
//   result    done, rsp            out         valid for the one cycle done is high
//
// A request enters every cycle; busy stays low.
// The pipe is 5 front stages, 12 divider stages (one quotient bit
// each, two dividers side by side) and one output register.
// Synchronous reset clears the valid bits of every stage.
// The receiver takes every result when shown, so nothing ever stalls.
`default_nettype none

module color_rgb_hsv_convert (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire crhc_pkg::req_t req,
  output logic                done,
  output crhc_pkg::rsp_t      rsp
);

  logic                         f_valid;
  logic [crhc_pkg::NUM_W-1:0]   num1, num2;
  logic [crhc_pkg::DEN_W-1:0]   den1, den2;
  crhc_pkg::side_t              f_side, d_side, d_side_unused;
  logic                         d_valid, d_valid_unused;
  logic [crhc_pkg::Q_W-1:0]     q1, q2;

  assign busy = 1'b0;

  crhc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .req      (req),
    .out_valid(f_valid),
    .num1     (num1),
    .den1     (den1),
    .num2     (num2),
    .den2     (den2),
    .side     (f_side)
  );

  crhc_div u_div1 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .num      (num1),
    .den      (den1),
    .in_side  (f_side),
    .out_valid(d_valid),
    .quo      (q1),
    .out_side (d_side)
  );

  crhc_div u_div2 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .num      (num2),
    .den      (den2),
    .in_side  (f_side),
    .out_valid(d_valid_unused),
    .quo      (q2),
    .out_side (d_side_unused)
  );

  crhc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .in_valid(d_valid),
    .q1      (q1),
    .q2      (q2),
    .side    (d_side),
    .done    (done),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire

### sv/crhc_checker.sv
// ----------------------------------------------------------------------------
// crhc_checker
// Port-level checks of the colour converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module crhc_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire crhc_pkg::req_t req,
  input wire logic           done,
  input wire crhc_pkg::rsp_t rsp
);

  localparam int LAT = 18;

  // Count cycles since reset until the pipe is fully known
  logic [4:0] warm;
  logic       accepted;

  assign accepted = start && !busy;

  always_ff @(posedge clk) begin
    if (rst)                warm <= '0;
    else if (warm != 5'(LAT)) warm <= warm + 5'd1;
  end

  `ASSERT_CLK_RST(a_never_busy, clk, rst, !busy)
  `ASSERT_CLK_RST(a_latency, clk, rst, (warm == 5'(LAT)) |-> (done == $past(accepted, LAT)))
  `ASSERT_CLK_RST(a_no_early, clk, rst, (warm != 5'(LAT)) |-> !done)
  `ASSERT_CLK_RST(a_hue_range, clk, rst, done |-> (rsp.out_a < crhc_pkg::HUE_TURN))
  `ASSERT_CLK(a_reset_quiet, clk, $past(rst) |-> !done)

endmodule

bind color_rgb_hsv_convert crhc_checker u_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .req  (req),
  .done (done),
  .rsp  (rsp)
);

`default_nettype wire
